>>> rtl/core/ale_pkg.sv
package ale_pkg;

	localparam int ALE_DEPTH = 8;

	typedef enum logic [2:0] {
		CMD_INS_FRONT = 3'd0,
		CMD_INS_POS   = 3'd1,
		CMD_REM_FRONT = 3'd2,
		CMD_REM_BACK  = 3'd3,
		CMD_REM_POS   = 3'd4,
		CMD_SEARCH    = 3'd5
	} cmd_t;

	typedef enum logic [2:0] {
		STS_OK       = 3'd0,
		STS_FULL     = 3'd1,
		STS_EMPTY    = 3'd2,
		STS_BADPOS   = 3'd3,
		STS_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_INS,
		OP_REM,
		OP_SRCH
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic decode;
		logic rd_issue;
		logic commit;
	} ale_ctl_t;

	typedef struct packed {
		logic scan_needed;
		logic last_read;
		logic out_free;
	} ale_sts_t;

endpackage

>>> rtl/core/ale_if.sv
interface ale_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         cmd;
	logic signed [31:0] data_in;
	logic [3:0]         position;

	modport source (output valid, output cmd, output data_in, output position, input ready);
	modport sink (input valid, input cmd, input data_in, input position, output ready);
endinterface

interface ale_rsp_if;
	logic               valid;
	logic               ready;
	logic [2:0]         status;
	logic signed [31:0] data_out;
	logic [2:0]         found_index;
	logic [3:0]         count_out;

	modport source (output valid, output status, output data_out, output found_index,
		output count_out, input ready);
	modport sink (input valid, input status, input data_out, input found_index,
		input count_out, output ready);
endinterface

>>> rtl/core/ale_ctrl.sv
module ale_ctrl
	import ale_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  ale_sts_t sts,
	output ale_ctl_t ctl
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_nxt = S_DECODE;
			end
			S_DECODE: begin
				state_nxt = sts.scan_needed ? S_SCAN : S_FINISH;
			end
			S_SCAN: begin
				if (sts.last_read) state_nxt = S_DRAIN;
			end
			S_DRAIN: begin
				state_nxt = S_FINISH;
			end
			S_FINISH: begin
				if (sts.out_free) state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready    = (state_q == S_IDLE);
		ctl.load     = (state_q == S_IDLE) && req_valid;
		ctl.decode   = (state_q == S_DECODE);
		ctl.rd_issue = (state_q == S_SCAN);
		ctl.commit   = (state_q == S_FINISH) && sts.out_free;
	end

endmodule

>>> rtl/core/ale_datapath.sv
module ale_datapath
	import ale_pkg::*;
#(
	parameter int DEPTH = ALE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ale_ctl_t           ctl,
	output ale_sts_t           sts,
	input  logic [2:0]         req_cmd,
	input  logic signed [31:0] req_data,
	input  logic [3:0]         req_pos,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output logic [2:0]         rsp_status,
	output logic signed [31:0] rsp_data,
	output logic [2:0]         rsp_index,
	output logic [3:0]         rsp_count
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int WW = (CW > 4) ? CW : 4;
	localparam int XW = (AW > 3) ? AW : 3;

	logic signed [31:0] mem_q [DEPTH];

	logic [2:0]         cmd_q;
	logic signed [31:0] word_q;
	logic [3:0]         pos_q;
	logic [CW-1:0]      count_q;
	op_t                op_q;
	logic [AW-1:0]      at_q;
	status_t            status_q;
	logic signed [31:0] removed_q;
	logic [AW-1:0]      found_q;
	logic               found_v_q;
	logic [AW-1:0]      rp_q;
	logic [CW-1:0]      left_q;

	logic               rd_valid_s1;
	logic [AW-1:0]      rd_addr_s1;
	logic signed [31:0] rd_data_s1;

	logic               out_valid_q;
	status_t            out_status_q;
	logic signed [31:0] out_data_q;
	logic [2:0]         out_index_q;
	logic [3:0]         out_count_q;

	logic [WW-1:0]      cnt_w;
	logic [WW-1:0]      pos_w;
	op_t                dec_op;
	status_t            dec_sts;
	logic [CW-1:0]      dec_at;
	logic [CW-1:0]      dec_len;
	logic [AW-1:0]      dec_rp;

	logic [CW-1:0]      cnt_nxt;
	logic [WW-1:0]      cnt_nxt_w;
	logic [XW-1:0]      found_x;

	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic signed [31:0] mem_wd;

	// command decode against the current count
	always_comb begin
		cnt_w   = WW'(count_q);
		pos_w   = WW'(pos_q);
		dec_op  = OP_NONE;
		dec_sts = STS_OK;
		dec_at  = '0;
		dec_len = '0;
		dec_rp  = '0;
		case (cmd_q)
			CMD_INS_FRONT, CMD_INS_POS: begin
				if (count_q == CW'(DEPTH)) begin
					dec_sts = STS_FULL;
				end else begin
					dec_op = OP_INS;
					if (cmd_q == CMD_INS_POS) begin
						dec_at = (pos_w > cnt_w) ? count_q : CW'(pos_q);
					end
					dec_len = count_q - dec_at;
					dec_rp  = AW'(count_q - 1'b1);
				end
			end
			CMD_REM_FRONT: begin
				if (count_q == '0) begin
					dec_sts = STS_EMPTY;
				end else begin
					dec_op  = OP_REM;
					dec_len = count_q;
				end
			end
			CMD_REM_BACK: begin
				if (count_q == '0) begin
					dec_sts = STS_EMPTY;
				end else begin
					dec_op  = OP_REM;
					dec_at  = count_q - 1'b1;
					dec_len = CW'(1);
					dec_rp  = AW'(count_q - 1'b1);
				end
			end
			CMD_REM_POS: begin
				if (count_q == '0) begin
					dec_sts = STS_EMPTY;
				end else if (pos_w >= cnt_w) begin
					dec_sts = STS_BADPOS;
				end else begin
					dec_op  = OP_REM;
					dec_at  = CW'(pos_q);
					dec_len = count_q - dec_at;
					dec_rp  = AW'(pos_q);
				end
			end
			CMD_SEARCH: begin
				dec_op  = OP_SRCH;
				dec_sts = STS_NOTFOUND;
				dec_len = count_q;
			end
			default: begin
				dec_op = OP_NONE;
			end
		endcase
	end

	always_comb begin
		case (op_q)
			OP_INS:  cnt_nxt = count_q + 1'b1;
			OP_REM:  cnt_nxt = count_q - 1'b1;
			default: cnt_nxt = count_q;
		endcase
		cnt_nxt_w = WW'(cnt_nxt);
		found_x   = XW'(found_q);
	end

	// single write port: shift stream or final insert
	always_comb begin
		mem_we = 1'b0;
		mem_wa = rd_addr_s1;
		mem_wd = rd_data_s1;
		if (ctl.commit && op_q == OP_INS) begin
			mem_we = 1'b1;
			mem_wa = at_q;
			mem_wd = word_q;
		end else if (rd_valid_s1) begin
			case (op_q)
				OP_INS: begin
					mem_we = 1'b1;
					mem_wa = rd_addr_s1 + 1'b1;
				end
				OP_REM: begin
					if (rd_addr_s1 != at_q) begin
						mem_we = 1'b1;
						mem_wa = rd_addr_s1 - 1'b1;
					end
				end
				default: begin
					mem_we = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_wa] <= mem_wd;
		if (ctl.rd_issue) rd_data_s1 <= mem_q[rp_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= ctl.rd_issue;
			if (ctl.commit) begin
				count_q     <= cnt_nxt;
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= req_cmd;
			word_q <= req_data;
			pos_q  <= req_pos;
		end
		if (ctl.decode) begin
			op_q      <= dec_op;
			status_q  <= dec_sts;
			at_q      <= AW'(dec_at);
			rp_q      <= dec_rp;
			left_q    <= dec_len;
			removed_q <= '0;
			found_q   <= '0;
			found_v_q <= 1'b0;
		end
		if (ctl.rd_issue) begin
			rd_addr_s1 <= rp_q;
			left_q     <= left_q - 1'b1;
			rp_q       <= (op_q == OP_INS) ? rp_q - 1'b1 : rp_q + 1'b1;
		end
		if (rd_valid_s1) begin
			if (op_q == OP_REM && rd_addr_s1 == at_q) removed_q <= rd_data_s1;
			if (op_q == OP_SRCH && !found_v_q && rd_data_s1 == word_q) begin
				found_v_q <= 1'b1;
				found_q   <= rd_addr_s1;
				status_q  <= STS_OK;
			end
		end
		if (ctl.commit) begin
			out_status_q <= status_q;
			out_data_q   <= removed_q;
			out_index_q  <= found_x[2:0];
			out_count_q  <= cnt_nxt_w[3:0];
		end
	end

	assign sts.scan_needed = (dec_len != '0);
	assign sts.last_read   = (left_q == CW'(1));
	assign sts.out_free    = !out_valid_q || rsp_ready;

	assign rsp_valid  = out_valid_q;
	assign rsp_status = out_status_q;
	assign rsp_data   = out_data_q;
	assign rsp_index  = out_index_q;
	assign rsp_count  = out_count_q;

endmodule

>>> rtl/core/array_list_engine.sv
// ordered list of up to DEPTH signed 32-bit words, packed from index 0
// req channel: cmd, data_in, position; one request is taken when valid and
// ready are both high, ready is high only while the engine is idle
// rsp channel: status, data_out, found_index, count_out; one response per request
// each request goes from acceptance to the response register in these steps,
// where len is the number of entries read: latch, decode, one read per entry
// through the single read port of the entry store, drain the last write
// (skipped when len is zero), commit; the next request is taken in the cycle
// after the commit
// inserts and removes shift entries one per cycle, search scans all entries
// a finished response sits in an output register; the engine takes the next
// request while it waits, and holds its commit only if the register is still full
// when the receiver stalls, the engine waits in its commit state
// reset clears the entry count and both valid flags; the entry store keeps its
// contents and is never read beyond the count
module array_list_engine
	import ale_pkg::*;
#(
	parameter int DEPTH = ALE_DEPTH
) (
	input logic         clk,
	input logic         arst_n,
	ale_req_if.sink     req,
	ale_rsp_if.source   rsp
);

	ale_ctl_t ctl;
	ale_sts_t sts;

	ale_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	ale_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.req_cmd    (req.cmd),
		.req_data   (req.data_in),
		.req_pos    (req.position),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.rsp_status (rsp.status),
		.rsp_data   (rsp.data_out),
		.rsp_index  (rsp.found_index),
		.rsp_count  (rsp.count_out)
	);

endmodule

>>> verif/array_list_engine_tb.sv
`timescale 1ns / 1ps

module array_list_engine_tb;
	import ale_pkg::*;

	localparam logic [2:0] CMD_RSVD_A = 3'd6;
	localparam logic [2:0] CMD_RSVD_B = 3'd7;
	localparam int RANDOM_REQUESTS = 1200;
	localparam int CYCLE_LIMIT = 800000;
	localparam int SETTLE_CYCLES = 3 * (ALE_DEPTH + 4);
	localparam int HOLD_OFF_CYCLES = 250;

	typedef enum logic [1:0] {
		BIAS_GROW,
		BIAS_MIXED,
		BIAS_SHRINK
	} bias_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] data_out;
		logic [2:0]         found_index;
		logic [3:0]         count_out;
	} list_result_t;

	class list_scoreboard;
		logic signed [31:0] words [ALE_DEPTH];
		int unsigned len;
		list_result_t awaited [$];

		function new();
			len = 0;
			foreach (words[k])
				words[k] = '0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function void note_request(logic [2:0] c, logic signed [31:0] d, logic [3:0] p);
			list_result_t res;
			int unsigned at;
			int unsigned k;
			res = '0;
			res.status = STS_OK;
			case (c)
				CMD_INS_FRONT, CMD_INS_POS: begin
					if (len >= ALE_DEPTH) begin
						res.status = STS_FULL;
					end else begin
						at = (c == CMD_INS_FRONT) ? 0 : p;
						if (at > len)
							at = len;
						for (k = len; k > at; k--)
							words[k] = words[k - 1];
						words[at] = d;
						len++;
					end
				end
				CMD_REM_FRONT, CMD_REM_BACK, CMD_REM_POS: begin
					if (len == 0) begin
						res.status = STS_EMPTY;
					end else if (c == CMD_REM_POS && p >= len) begin
						res.status = STS_BADPOS;
					end else begin
						at = (c == CMD_REM_FRONT) ? 0 : (c == CMD_REM_BACK) ? len - 1 : p;
						res.data_out = words[at];
						for (k = at; k + 1 < len; k++)
							words[k] = words[k + 1];
						len--;
					end
				end
				CMD_SEARCH: begin
					res.status = STS_NOTFOUND;
					for (k = 0; k < len; k++) begin
						if (words[k] == d) begin
							res.status = STS_OK;
							res.found_index = k[2:0];
							break;
						end
					end
				end
				default: ;
			endcase
			res.count_out = len[3:0];
			awaited.push_back(res);
		endfunction

		function string check_response(list_result_t got);
			list_result_t exp;
			string msg;
			msg = "";
			if (awaited.size() == 0)
				return $sformatf("unexpected response status=%0d data=%0d count=%0d",
					got.status, got.data_out, got.count_out);
			exp = awaited.pop_front();
			if (got.status !== exp.status)
				msg = {msg, $sformatf(" status %0d/%0d", got.status, exp.status)};
			if (got.data_out !== exp.data_out)
				msg = {msg, $sformatf(" data_out %0d/%0d", got.data_out, exp.data_out)};
			if (got.found_index !== exp.found_index)
				msg = {msg, $sformatf(" found_index %0d/%0d", got.found_index,
					exp.found_index)};
			if (got.count_out !== exp.count_out)
				msg = {msg, $sformatf(" count_out %0d/%0d", got.count_out, exp.count_out)};
			return msg;
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycle_count;
	int   error_count;
	bit   tx_quiet;
	bit   rx_quiet;
	bit   hold_off_req;

	ale_req_if req_if ();
	ale_rsp_if rsp_if ();

	list_scoreboard sb;

	array_list_engine u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("cycle %0d: response mismatch (got/exp):%s", cycle_count, msg);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// response side: random stalls, one long hold-off on request
	initial begin
		int gap_left;
		int hold_left;
		list_result_t got;
		string msg;
		gap_left = 0;
		hold_left = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
				got.status = rsp_if.status;
				got.data_out = rsp_if.data_out;
				got.found_index = rsp_if.found_index;
				got.count_out = rsp_if.count_out;
				msg = sb.check_response(got);
				if (msg != "")
					report_mismatch(msg);
			end
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else if (gap_left > 0 && !rx_quiet) begin
				gap_left--;
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
				gap_left = rx_quiet ? 0 : pick_gap();
			end
		end
	end

	task automatic issue_request(input logic [2:0] c, input logic signed [31:0] d,
		input logic [3:0] p);
		int gap;
		req_if.valid <= 1'b1;
		req_if.cmd <= c;
		req_if.data_in <= d;
		req_if.position <= p;
		do
			@(posedge clk);
		while (req_if.ready !== 1'b1);
		sb.note_request(c, d, p);
		gap = tx_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_responses();
		req_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [31:0] pick_word();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return $signed($urandom_range(0, 7)) - 4;
		else if (r < 45)
			return 32'sh7fffffff;
		else if (r < 50)
			return 32'sh80000000;
		return $urandom;
	endfunction

	function automatic logic [2:0] pick_cmd(bias_t bias);
		int r;
		int ins_cut;
		int rem_cut;
		r = $urandom_range(0, 99);
		ins_cut = (bias == BIAS_GROW) ? 60 : (bias == BIAS_SHRINK) ? 20 : 40;
		rem_cut = ins_cut + ((bias == BIAS_GROW) ? 20 : (bias == BIAS_SHRINK) ? 60 : 35);
		if (r < ins_cut)
			return ($urandom_range(0, 1) != 0) ? CMD_INS_POS : CMD_INS_FRONT;
		else if (r < rem_cut)
			case ($urandom_range(0, 2))
				0: return CMD_REM_FRONT;
				1: return CMD_REM_BACK;
				default: return CMD_REM_POS;
			endcase
		else if (r < 97)
			return CMD_SEARCH;
		return ($urandom_range(0, 1) != 0) ? CMD_RSVD_B : CMD_RSVD_A;
	endfunction

	task automatic random_request(bias_t bias);
		logic [2:0] c;
		logic signed [31:0] d;
		logic [3:0] p;
		c = pick_cmd(bias);
		d = pick_word();
		if (c == CMD_SEARCH && sb.len > 0 && $urandom_range(0, 99) < 60)
			d = sb.words[$urandom_range(0, sb.len - 1)];
		if ($urandom_range(0, 99) < 70)
			p = 4'($urandom_range(0, sb.len));
		else
			p = 4'($urandom_range(0, ALE_DEPTH));
		issue_request(c, d, p);
	endtask

	initial begin
		int i;
		bias_t bias;
		clk = 1'b0;
		arst_n = 1'b0;
		cycle_count = 0;
		error_count = 0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		hold_off_req = 1'b0;
		req_if.valid = 1'b0;
		req_if.cmd = CMD_INS_FRONT;
		req_if.data_in = '0;
		req_if.position = '0;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list and unused codes
		issue_request(CMD_REM_FRONT, 32'sd0, 4'd0);
		issue_request(CMD_REM_BACK, 32'sd0, 4'd0);
		issue_request(CMD_REM_POS, 32'sd0, 4'd0);
		issue_request(CMD_SEARCH, 32'sd0, 4'd0);
		issue_request(CMD_RSVD_A, -32'sd1, 4'd8);
		issue_request(CMD_RSVD_B, 32'sd1, 4'd1);
		// inserts, append past count, duplicates, searches, bad and valid remove positions
		issue_request(CMD_INS_FRONT, 32'sh7fffffff, 4'd0);
		issue_request(CMD_INS_POS, 32'sh80000000, 4'd0);
		issue_request(CMD_INS_POS, -32'sd1, 4'd8);
		issue_request(CMD_INS_POS, 32'sd0, 4'd1);
		issue_request(CMD_INS_FRONT, 32'sd5, 4'd15);
		issue_request(CMD_INS_POS, 32'sd5, 4'd2);
		issue_request(CMD_SEARCH, 32'sd5, 4'd0);
		issue_request(CMD_SEARCH, 32'sd12345, 4'd0);
		issue_request(CMD_REM_POS, 32'sd0, 4'd8);
		issue_request(CMD_REM_POS, 32'sd0, 4'd5);
		// fill up, then full list cases
		issue_request(CMD_INS_POS, 32'shaaaaaaaa, 4'd3);
		issue_request(CMD_INS_POS, 32'sh55555555, 4'd8);
		issue_request(CMD_INS_FRONT, 32'sd1, 4'd0);
		issue_request(CMD_INS_FRONT, 32'sd7, 4'd0);
		issue_request(CMD_INS_POS, 32'sd7, 4'd3);
		issue_request(CMD_SEARCH, sb.words[sb.len - 1], 4'd0);
		issue_request(CMD_REM_BACK, 32'sd0, 4'd0);
		issue_request(CMD_REM_FRONT, 32'sd0, 4'd0);
		issue_request(CMD_REM_POS, 32'sd0, 4'd0);
		drain_responses();

		for (i = 0; i < RANDOM_REQUESTS; i++) begin
			case ((i / 150) % 4)
				0: bias = BIAS_GROW;
				2: bias = BIAS_SHRINK;
				default: bias = BIAS_MIXED;
			endcase
			if (i == 300) begin
				hold_off_req = 1'b1;
				tx_quiet = 1'b1;
			end
			if (i == 340)
				tx_quiet = 1'b0;
			if (i == 450 || i == 900)
				drain_responses();
			if (i == 600) begin
				tx_quiet = 1'b1;
				rx_quiet = 1'b1;
			end
			if (i == 700) begin
				tx_quiet = 1'b0;
				rx_quiet = 1'b0;
			end
			random_request(bias);
		end

		drain_responses();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
